>>> hw/rtl/bsm_pkg.sv
// Shared types and codes for the barrier sync manager.
`timescale 1ns / 1ps

package bsm_pkg;

  localparam logic FUNC_INIT   = 1'b0;
  localparam logic FUNC_ARRIVE = 1'b1;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_FAILED = 1'b1;

  localparam int NODE_W = 5;
  localparam int TAG_W  = 32;
  localparam int IDX_W  = 6;
  localparam int PARTY_W = 6;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_REL   = 4'b1000
  } state_t;

endpackage

>>> hw/rtl/barrier_sync_manager_unit.sv
// Barrier sync manager: barrier table and per-barrier waiter queues in synchronous memories.
// An init or FAILED reply goes from the lookup state into the output register, once that register is free.
// Items are taken one at a time (entry read, then modify and write back), with the input stalled until
// the item is done; a completing arrival walks its waiter queue at one reply per cycle while out_stall is low.
// Reset: control state clears at once, then a clearing pass zeroes the entry
// memory, one entry a cycle, with the input stalled; the waiter memory is never cleared.
`timescale 1ns / 1ps

module barrier_sync_manager_unit
  import bsm_pkg::*;
#(
  parameter int NUM_BARRIERS = 64,
  parameter int MAX_NODES    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [IDX_W-1:0]   barrier_index,
  input  logic [NODE_W-1:0]  requester,
  input  logic [TAG_W-1:0]   sequence_tag,
  input  logic [PARTY_W-1:0] party_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [NODE_W-1:0]  dest_node,
  output logic [TAG_W-1:0]   reply_tag,
  output logic               status,
  output logic               last
);

  localparam int QDEPTH = MAX_NODES + 1;
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam int BW     = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1;
  localparam int WDEPTH = NUM_BARRIERS * QDEPTH;
  localparam int AW     = $clog2(WDEPTH);
  localparam int WW     = NODE_W + TAG_W;

  typedef struct packed {
    logic          present;
    logic          active;
    logic [CW-1:0] remaining;
    logic [CW-1:0] fill;
  } entry_t;

  entry_t        ent_mem [NUM_BARRIERS];
  entry_t        ent_q;
  logic [WW-1:0] wq_mem [WDEPTH];
  logic [WW-1:0] wq_q;

  state_t state;
  logic [BW-1:0] clr_cnt;

  logic               req_func;
  logic [IDX_W-1:0]   req_idx;
  logic [NODE_W-1:0]  req_node;
  logic [TAG_W-1:0]   req_tag;
  logic [PARTY_W-1:0] req_party;

  logic [AW-1:0] rel_addr;
  logic [CW-1:0] rel_left;
  logic          pend_valid;
  logic          pend_last;

  logic          accept;
  logic          in_range;
  logic          hit;
  logic          single;
  logic          out_free;
  logic          go;
  logic [BW-1:0] b;
  logic [AW-1:0] base;
  logic [CW-1:0] cnt_load;
  logic [CW-1:0] rem_cur;
  logic [CW-1:0] fill_cur;
  logic [CW-1:0] rem_dec;
  logic [CW-1:0] fill_new;
  logic          fill_ok;
  logic          done;
  logic          load_out;
  logic          issue;

  logic          ent_we;
  logic [BW-1:0] ent_waddr;
  entry_t        ent_wdata;
  logic          wq_we;
  logic [AW-1:0] wq_waddr;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    in_range = (32'(req_idx) < NUM_BARRIERS);
    b        = BW'(req_idx);
    base     = AW'(b) * AW'(QDEPTH);
    hit      = in_range && ent_q.present;
    single   = (req_func == FUNC_INIT) || !hit;
    go       = (state == S_LOOK) && (!single || out_free);

    if (req_party == '0) begin
      cnt_load = CW'(1);
    end else if (32'(req_party) > QDEPTH) begin
      cnt_load = CW'(QDEPTH);
    end else begin
      cnt_load = CW'(req_party);
    end
    rem_cur  = ent_q.active ? ent_q.remaining : cnt_load;
    fill_cur = ent_q.active ? ent_q.fill : '0;
    rem_dec  = (rem_cur == '0) ? rem_cur : rem_cur - CW'(1);
    fill_ok  = (32'(fill_cur) < QDEPTH);
    fill_new = fill_ok ? fill_cur + CW'(1) : fill_cur;
    done     = (rem_dec == '0);

    load_out = (state == S_REL) && pend_valid && out_free;
    issue    = (state == S_REL) && (rel_left != '0) && (!pend_valid || load_out);
  end

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = b;
    ent_wdata = '0;
    wq_we     = 1'b0;
    wq_waddr  = base + AW'(fill_cur);
    if (state == S_CLEAR) begin
      ent_we    = 1'b1;
      ent_waddr = clr_cnt;
    end else if (go) begin
      if (req_func == FUNC_INIT) begin
        ent_we            = in_range;
        ent_wdata         = ent_q;
        ent_wdata.present = 1'b1;
      end else if (hit) begin
        ent_we            = 1'b1;
        ent_wdata.present = 1'b1;
        if (!done) begin
          ent_wdata.active    = 1'b1;
          ent_wdata.remaining = rem_dec;
          ent_wdata.fill      = fill_new;
        end
        wq_we = fill_ok;
      end
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (accept) begin
      ent_q <= ent_mem[BW'(barrier_index)];
    end
  end

  // waiter memory
  always_ff @(posedge clk) begin
    if (wq_we) begin
      wq_mem[wq_waddr] <= {req_node, req_tag};
    end
    if (issue) begin
      wq_q <= wq_mem[rel_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func;
      req_idx   <= barrier_index;
      req_node  <= requester;
      req_tag   <= sequence_tag;
      req_party <= party_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      rel_addr   <= '0;
      rel_left   <= '0;
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BW'(1);
          if (clr_cnt == BW'(NUM_BARRIERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (go) begin
            if (!single && done) begin
              rel_addr <= base;
              rel_left <= fill_new;
              state    <= S_REL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_REL: begin
          if (issue) begin
            rel_addr   <= rel_addr + AW'(1);
            rel_left   <= rel_left - CW'(1);
            pend_last  <= (rel_left == CW'(1));
            pend_valid <= 1'b1;
          end else if (load_out) begin
            pend_valid <= 1'b0;
          end
          if ((rel_left == '0) && (!pend_valid || load_out)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && single) begin
      out_valid <= 1'b1;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && single) begin
      dest_node <= req_node;
      reply_tag <= req_tag;
      status    <= (req_func == FUNC_INIT) ? ST_OK : ST_FAILED;
      last      <= 1'b1;
    end else if (load_out) begin
      dest_node <= wq_q[WW-1:TAG_W];
      reply_tag <= wq_q[TAG_W-1:0];
      status    <= ST_OK;
      last      <= pend_last;
    end
  end

endmodule

>>> test/tb.sv
// Self-checking testbench for the barrier sync manager unit.
`timescale 1ns / 1ps

module tb
  import bsm_pkg::*;
();

  localparam int NUM_BARRIERS = 64;
  localparam int MAX_NODES    = 32;
  localparam int QDEPTH       = MAX_NODES + 1;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 40;
  localparam int SEND_PCT [4] = '{0, 62, 0, 13};
  localparam int RECV_PCT [4] = '{0, 0, 62, 13};

  typedef struct packed {
    logic               fn;
    logic [IDX_W-1:0]   idx;
    logic [NODE_W-1:0]  node;
    logic [TAG_W-1:0]   tag;
    logic [PARTY_W-1:0] party;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TAG_W-1:0]  tag;
    logic              st;
    logic              fin;
  } reply_t;

  typedef struct packed {
    req_t rq;
    logic typed;
    logic st;
  } step_t;

  // typed rows: single reply {node, tag, st, last=1}
  localparam step_t PLAN [0:17] = '{
    '{'{FUNC_ARRIVE, 6'd5,  5'd3,  32'h0000_0011, 6'd1},  1'b1, ST_FAILED},
    '{'{FUNC_ARRIVE, 6'd63, 5'd31, 32'hFFFF_FFFF, 6'd63}, 1'b1, ST_FAILED},
    '{'{FUNC_INIT,   6'd0,  5'd0,  32'h0000_0000, 6'd0},  1'b1, ST_OK},
    '{'{FUNC_INIT,   6'd63, 5'd31, 32'hFFFF_FFFF, 6'd63}, 1'b1, ST_OK},
    '{'{FUNC_INIT,   6'd0,  5'd21, 32'hAAAA_AAAA, 6'd5},  1'b1, ST_OK},
    '{'{FUNC_ARRIVE, 6'd0,  5'd10, 32'h5555_5555, 6'd0},  1'b0, ST_OK},
    '{'{FUNC_ARRIVE, 6'd63, 5'd1,  32'h0000_0001, 6'd3},  1'b0, ST_OK},
    '{'{FUNC_INIT,   6'd63, 5'd2,  32'h0000_0002, 6'd1},  1'b1, ST_OK},
    '{'{FUNC_ARRIVE, 6'd63, 5'd2,  32'h0000_0003, 6'd1},  1'b0, ST_OK},
    '{'{FUNC_ARRIVE, 6'd63, 5'd30, 32'hFFFF_FFFE, 6'd1},  1'b0, ST_OK},
    '{'{FUNC_ARRIVE, 6'd0,  5'd31, 32'hDEAD_BEEF, 6'd1},  1'b0, ST_OK},
    '{'{FUNC_INIT,   6'd42, 5'd20, 32'h8000_0000, 6'd32}, 1'b1, ST_OK},
    '{'{FUNC_ARRIVE, 6'd42, 5'd11, 32'h7FFF_FFFF, 6'd2},  1'b0, ST_OK},
    '{'{FUNC_ARRIVE, 6'd21, 5'd4,  32'h1234_5678, 6'd2},  1'b1, ST_FAILED},
    '{'{FUNC_ARRIVE, 6'd42, 5'd12, 32'h0000_0000, 6'd40}, 1'b0, ST_OK},
    '{'{FUNC_INIT,   6'd21, 5'd0,  32'h0000_0000, 6'd0},  1'b1, ST_OK},
    '{'{FUNC_ARRIVE, 6'd21, 5'd5,  32'hCAFE_F00D, 6'd33}, 1'b0, ST_OK},
    '{'{FUNC_ARRIVE, 6'd0,  5'd9,  32'h0F0F_0F0F, 6'd63}, 1'b0, ST_OK}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = 1'b0;
  logic [IDX_W-1:0]   barrier_index = '0;
  logic [NODE_W-1:0]  requester = '0;
  logic [TAG_W-1:0]   sequence_tag = '0;
  logic [PARTY_W-1:0] party_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [NODE_W-1:0]  dest_node;
  logic [TAG_W-1:0]   reply_tag;
  logic               status;
  logic               last;

  barrier_sync_manager_unit #(
    .NUM_BARRIERS(NUM_BARRIERS),
    .MAX_NODES(MAX_NODES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .barrier_index(barrier_index),
    .requester(requester),
    .sequence_tag(sequence_tag),
    .party_count(party_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dest_node(dest_node),
    .reply_tag(reply_tag),
    .status(status),
    .last(last)
  );

  // barrier table as the block should hold it
  bit                    bar_live [NUM_BARRIERS];
  bit                    bar_open [NUM_BARRIERS];
  int                    bar_need [NUM_BARRIERS];
  int                    bar_count [NUM_BARRIERS];
  logic [NODE_W+TAG_W-1:0] bar_waiters [NUM_BARRIERS][QDEPTH];

  reply_t pending_replies [$];
  int     fails = 0;
  int     send_pct = 0;
  int     recv_pct = 0;
  bit     hold_kick = 1'b0;
  bit     hold_seen = 1'b0;
  int     hold_left = 0;
  int     quiet = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic barrier_update(input req_t rq, input bit keep);
    reply_t rp;
    int     b;
    int     cnt;
    int     i;
    b = int'(rq.idx);
    rp.node = rq.node;
    rp.tag  = rq.tag;
    rp.fin  = 1'b1;
    if (rq.fn == FUNC_INIT) begin
      bar_live[b] = 1'b1;
      rp.st = ST_OK;
      if (keep) pending_replies.push_back(rp);
      return;
    end
    if (!bar_live[b]) begin
      rp.st = ST_FAILED;
      if (keep) pending_replies.push_back(rp);
      return;
    end
    if (!bar_open[b]) begin
      cnt = int'(rq.party);
      if (cnt == 0) cnt = 1;
      if (cnt > QDEPTH) cnt = QDEPTH;
      bar_open[b]  = 1'b1;
      bar_need[b]  = cnt;
      bar_count[b] = 0;
    end
    if (bar_need[b] > 0) bar_need[b]--;
    if (bar_count[b] < QDEPTH) begin
      bar_waiters[b][bar_count[b]] = {rq.node, rq.tag};
      bar_count[b]++;
    end
    if (bar_need[b] != 0) return;
    for (i = 0; i < bar_count[b]; i++) begin
      rp.node = bar_waiters[b][i][NODE_W+TAG_W-1:TAG_W];
      rp.tag  = bar_waiters[b][i][TAG_W-1:0];
      rp.st   = ST_OK;
      rp.fin  = (i + 1 == bar_count[b]);
      if (keep) pending_replies.push_back(rp);
    end
    bar_count[b] = 0;
    bar_open[b]  = 1'b0;
  endtask

  task automatic offer(input req_t rq, input bit keep);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= rq.fn;
    barrier_index <= rq.idx;
    requester     <= rq.node;
    sequence_tag  <= rq.tag;
    party_count   <= rq.party;
    do @(posedge clk); while (in_stall);
    barrier_update(rq, keep);
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_kick) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: dest_node %0d reply_tag %h", dest_node, reply_tag);
        fails++;
      end else begin
        want = pending_replies.pop_front();
        if (dest_node !== want.node) begin
          $error("dest_node: expected %0d, got %0d", want.node, dest_node);
          fails++;
        end
        if (reply_tag !== want.tag) begin
          $error("reply_tag: expected %h, got %h", want.tag, reply_tag);
          fails++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          fails++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int     n;
    int     k;
    int     roll;
    int     p;
    int     hot [3];
    req_t   rq;
    reply_t rp;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < $size(PLAN); n++) begin
      offer(PLAN[n].rq, !PLAN[n].typed);
      if (PLAN[n].typed) begin
        rp.node = PLAN[n].rq.node;
        rp.tag  = PLAN[n].rq.tag;
        rp.st   = PLAN[n].st;
        rp.fin  = 1'b1;
        pending_replies.push_back(rp);
      end
    end

    // barriers 0 and 21 are left gathering by the directed rows
    hot[0] = 0;
    hot[1] = 21;
    hot[2] = $urandom_range(0, NUM_BARRIERS - 1);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        send_pct = SEND_PCT[(n / 50) % 4];
        recv_pct = RECV_PCT[(n / 50) % 4];
        for (k = 0; k < 3; k++) begin
          if (!bar_open[hot[k]] && (n == 0 || $urandom_range(0, 2) == 0)) begin
            if (n != 0) hot[k] = $urandom_range(0, NUM_BARRIERS - 1);
            rq.fn    = FUNC_INIT;
            rq.idx   = IDX_W'(hot[k]);
            rq.node  = NODE_W'($urandom_range(0, 31));
            rq.tag   = $urandom;
            rq.party = PARTY_W'($urandom_range(0, 63));
            offer(rq, 1'b1);
          end
        end
      end
      if (n == 30) hold_kick = ~hold_kick;
      if (n == 260) begin
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
      end

      roll     = $urandom_range(0, 99);
      rq.fn    = FUNC_ARRIVE;
      rq.idx   = IDX_W'(hot[$urandom_range(0, 2)]);
      rq.node  = NODE_W'($urandom_range(0, 31));
      rq.tag   = $urandom;
      rq.party = PARTY_W'($urandom_range(0, 63));
      if (roll < 8) begin
        rq.fn  = FUNC_INIT;
        rq.idx = IDX_W'($urandom_range(0, NUM_BARRIERS - 1));
      end else if (roll < 16) begin
        rq.idx = IDX_W'($urandom_range(0, NUM_BARRIERS - 1));
      end else if (roll < 20) begin
        rq.fn = FUNC_INIT;
      end else if (!bar_open[rq.idx]) begin
        p = $urandom_range(0, 99);
        if (p < 8) rq.party = '0;
        else if (p < 75) rq.party = PARTY_W'($urandom_range(1, 4));
        else if (p < 90) rq.party = PARTY_W'($urandom_range(5, QDEPTH));
        else rq.party = PARTY_W'($urandom_range(QDEPTH + 1, 63));
      end
      offer(rq, 1'b1);
    end

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bsm_pkg.sv
hw/rtl/barrier_sync_manager_unit.sv
test/tb.sv
